FILE: rtl/core/prc_pkg.sv
// ---------------------------------------------------------------------------
// prc_pkg
// shared types and constants of the paired read consensus block
// ---------------------------------------------------------------------------
package prc_pkg;

  localparam logic [7:0] GAP_BYTE = 8'h2D;
  localparam logic [7:0] N_BYTE   = 8'h4E;

  // mismatch rule codes
  localparam logic [1:0] WIN_FIRST  = 2'd1;
  localparam logic [1:0] WIN_SECOND = 2'd2;

  // configuration register indexes
  localparam logic CFG_WINNER = 1'b0;
  localparam logic CFG_TRIM   = 1'b1;

  localparam int unsigned CFG_DATA_W = 2;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // classified column handed from front to back
  typedef struct packed {
    logic [7:0] cons;
    logic       has;
    logic       hold;
    logic       last;
  } prc_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SEND = 3'b100
  } back_state_e;

endpackage

FILE: rtl/core/prc_in_if.sv
// ---------------------------------------------------------------------------
// prc_in_if
// column channel: one byte of each read and the last-column mark
// ---------------------------------------------------------------------------
interface prc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_one;
  logic [7:0] base_two;
  logic       last_column;

  modport source (output valid, output base_one, output base_two, output last_column,
                  input ready);
  modport sink   (input valid, input base_one, input base_two, input last_column,
                  output ready);
endinterface

FILE: rtl/core/prc_out_if.sv
// ---------------------------------------------------------------------------
// prc_out_if
// result channel: one consensus byte or a bare end marker
// ---------------------------------------------------------------------------
interface prc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_base;
  logic       base_present;
  logic       end_of_pair;
  logic       hold_overflow;

  modport source (output valid, output out_base, output base_present,
                  output end_of_pair, output hold_overflow, input ready);
  modport sink   (input valid, input out_base, input base_present,
                  input end_of_pair, input hold_overflow, output ready);
endinterface

FILE: rtl/core/prc_ram.sv
// ---------------------------------------------------------------------------
// prc_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module prc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 63,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/prc_front.sv
// ---------------------------------------------------------------------------
// prc_front
// takes columns, forms the consensus byte and classifies the column
// ---------------------------------------------------------------------------
module prc_front
  import prc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  prc_in_if.sink     in_if,
  input  logic [1:0] winner_i,
  input  logic       trim_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output prc_cmd_t   q_cmd_o
);

  logic       lead_q, lead_d;
  logic       lead_now;
  logic [7:0] cons;
  logic       b1_gap, b2_gap;

  assign b1_gap = (in_if.base_one == GAP_BYTE);
  assign b2_gap = (in_if.base_two == GAP_BYTE);

  always_comb begin
    priority if ((in_if.base_one == in_if.base_two) || b2_gap) begin
      cons = in_if.base_one;
    end else if (b1_gap) begin
      cons = in_if.base_two;
    end else if (winner_i == WIN_FIRST) begin
      cons = in_if.base_one;
    end else if (winner_i == WIN_SECOND) begin
      cons = in_if.base_two;
    end else begin
      cons = N_BYTE;
    end
  end

  assign lead_now = lead_q && b1_gap;

  assign in_if.ready = !q_full_i;
  assign q_push_o    = in_if.valid && !q_full_i;

  always_comb begin
    q_cmd_o.cons = cons;
    q_cmd_o.has  = (cons != GAP_BYTE) && !(trim_i && lead_now);
    q_cmd_o.hold = trim_i && b2_gap;
    q_cmd_o.last = in_if.last_column;
  end

  // leading run restarts after the final column of a pair
  always_comb begin
    lead_d = lead_q;
    if (q_push_o) begin
      lead_d = in_if.last_column ? 1'b1 : lead_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 1'b1;
    end else begin
      lead_q <= lead_d;
    end
  end

endmodule

FILE: rtl/core/prc_queue.sv
// ---------------------------------------------------------------------------
// prc_queue
// short command queue between the front and the back
// ---------------------------------------------------------------------------
module prc_queue
  import prc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  prc_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output prc_cmd_t cmd_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  prc_cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i  ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

endmodule

FILE: rtl/core/prc_back.sv
// ---------------------------------------------------------------------------
// prc_back
// carries out commands: holds gapped runs, flushes them, drives results
// ---------------------------------------------------------------------------
module prc_back
  import prc_pkg::*;
#(
  parameter int unsigned HOLD_DEPTH = 63
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  prc_cmd_t q_cmd_i,
  output logic     q_pop_o,
  prc_out_if.source out_if
);

  localparam int unsigned AddrW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(HOLD_DEPTH + 1);

  back_state_e     state_q, state_d;
  prc_cmd_t        cmd_q, cmd_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            ovf_q, ovf_d;

  logic            ovalid_q, ovalid_d;
  logic [7:0]      obase_q, obase_d;
  logic            opres_q, opres_d;
  logic            oend_q, oend_d;
  logic            oovf_q, oovf_d;
  logic            out_free;

  logic            ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_rdata;

  logic            flush_more, flushed, do_store, full, emit_own, emit_bare, need_out;
  logic            load;

  prc_ram #(
    .Width (8),
    .Depth (HOLD_DEPTH)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_q.cons),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !ovalid_q || out_if.ready;
  assign flush_more = !cmd_q.hold && (idx_q != count_q);
  assign flushed    = !cmd_q.hold && (count_q != '0);
  assign do_store   = cmd_q.has && cmd_q.hold;
  assign full       = (count_q == CntW'(HOLD_DEPTH));
  assign emit_own   = cmd_q.has && !cmd_q.hold;
  assign emit_bare  = cmd_q.last && !flushed && !emit_own;
  assign need_out   = emit_own || emit_bare;
  assign ram_waddr  = count_q[AddrW-1:0];
  assign ram_raddr  = idx_q[AddrW-1:0];

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    count_d = count_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    q_pop_o = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    load    = 1'b0;
    obase_d = obase_q;
    opres_d = opres_q;
    oend_d  = oend_q;
    oovf_d  = oovf_q;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (flush_more) begin
          ram_re  = 1'b1;
          state_d = S_SEND;
        end else if (!need_out || out_free) begin
          if (do_store && !full) begin
            ram_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end
          if (do_store && full) begin
            ovf_d = 1'b1;
          end
          if (!cmd_q.hold) begin
            count_d = '0;
          end
          if (need_out) begin
            load    = 1'b1;
            obase_d = emit_own ? cmd_q.cons : 8'h00;
            opres_d = emit_own;
            oend_d  = cmd_q.last;
            oovf_d  = cmd_q.last && (ovf_q || (do_store && full));
          end
          if (cmd_q.last) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_SEND: begin
        if (out_free) begin
          load    = 1'b1;
          obase_d = ram_rdata;
          opres_d = 1'b1;
          oend_d  = cmd_q.last && !cmd_q.has && ((idx_q + CntW'(1)) == count_q);
          oovf_d  = cmd_q.last && !cmd_q.has && ((idx_q + CntW'(1)) == count_q) && ovf_q;
          idx_d   = idx_q + CntW'(1);
          state_d = S_EXEC;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_if.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    obase_q <= obase_d;
    opres_q <= opres_d;
    oend_q  <= oend_d;
    oovf_q  <= oovf_d;
  end

  assign out_if.valid         = ovalid_q;
  assign out_if.out_base      = obase_q;
  assign out_if.base_present  = opres_q;
  assign out_if.end_of_pair   = oend_q;
  assign out_if.hold_overflow = oovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(HOLD_DEPTH))
    else $error("hold count beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q <= count_q)
    else $error("flush index passed hold count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_SEND) |-> $past(state_q == S_EXEC || state_q == S_SEND))
    else $error("flush send without a preceding read");

endmodule

FILE: rtl/core/paired_read_consensus_top.sv
// ---------------------------------------------------------------------------
// paired_read_consensus_top
// streaming consensus of two aligned reads, one column per word
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  in_if     in   valid / ready    base_one, base_two, last_column
//  out_if    out  valid / ready    out_base, base_present, end_of_pair, hold_overflow
//  cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i (no read-back)
//
//  the back end pops a column's command in idle and acts on it in exec; each
//  held base flushed ahead of it adds a hold ram read, then a result register
//  load, set by the single ram read port
//  a two-deep command queue lets the front take columns while a flush runs
//  reset clears all control state at once; the hold ram needs no clearing
//  pass, only entries below the hold count are ever read
//  a stalled result holds in the output register; the back waits on it

module paired_read_consensus_top
  import prc_pkg::*;
#(
  parameter int unsigned HOLD_DEPTH = 63
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  prc_in_if.sink                in_if,
  prc_out_if.source             out_if,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [1:0] winner_q, winner_d;
  logic       trim_q, trim_d;

  // front to queue
  logic       q_push, q_full;
  prc_cmd_t   push_cmd;

  // queue to back
  logic       q_pop, q_valid;
  prc_cmd_t   pop_cmd;

  always_comb begin
    winner_d = winner_q;
    trim_d   = trim_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINNER: winner_d = cfg_data_i[1:0];
        CFG_TRIM:   trim_d   = cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      winner_q <= 2'd0;
      trim_q   <= 1'b0;
    end else begin
      winner_q <= winner_d;
      trim_q   <= trim_d;
    end
  end

  // front: consensus byte, leading overhang tracking, hold decision
  prc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .winner_i (winner_q),
    .trim_i   (trim_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  // decouples column intake from flush bursts
  prc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  // back: hold store, flush sequencing and result register
  prc_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (pop_cmd),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );

endmodule

FILE: dv/paired_read_consensus_top_tb.sv
// ---------------------------------------------------------------------------
// paired_read_consensus_top_tb
// drives aligned column words into the consensus block under changing
// settings and idling, predicts every result word and checks each one
// ---------------------------------------------------------------------------
module paired_read_consensus_top_tb;
  import prc_pkg::*;

  localparam int unsigned HOLD_DEPTH    = 63;
  // results can only trail the last word by a few commands in the queue
  localparam int unsigned SETTLE_CYCLES = 16;
  // room for a full hold store flush, a ram read and a result load a base, plus slack
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // columns of random pairs in each idling phase, at least
  localparam int          RANDOM_COLS   = 22;

  // mismatch rule values that fall through to an 'N'
  localparam logic [1:0] WIN_N_ZERO  = 2'd0;
  localparam logic [1:0] WIN_N_THREE = 2'd3;

  // A, C, G, T
  localparam logic [31:0] NUCLEOTIDES = {8'h41, 8'h43, 8'h47, 8'h54};

  typedef struct packed {
    logic [7:0] base;
    logic       present;
    logic       eop;
    logic       ovf;
  } column_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  prc_in_if  col_ch ();
  prc_out_if res_ch ();

  paired_read_consensus_top #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_if     (col_ch),
    .out_if    (res_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // predictor state: registers as last written, plus the per-pair state
  logic [1:0]     winner_sel;
  logic           trim_on;
  logic           leading;
  logic [7:0]     held_q[$];
  logic           overflowed;
  column_result_t due_results[$];

  int fail_count;
  int cycles;
  int src_idle_pct;
  int snk_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, counted in clock cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random back-pressure at the rate of the current phase
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  // every accepted result word is held against the oldest prediction
  always @(posedge clk) begin : check_results
    column_result_t got;
    column_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = {res_ch.out_base, res_ch.base_present, res_ch.end_of_pair,
             res_ch.hold_overflow};
      if (due_results.size() == 0) begin
        $display("%0t: expected no result, got base %h present %b end %b ovf %b",
                 $time, got.base, got.present, got.eop, got.ovf);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (got.base !== want.base || got.present !== want.present ||
            got.eop !== want.eop || got.ovf !== want.ovf) begin
          $display("%0t: expected base %h present %b end %b ovf %b,",
                   $time, want.base, want.present, want.eop, want.ovf,
                   " got base %h present %b end %b ovf %b",
                   got.base, got.present, got.eop, got.ovf);
          fail_count++;
        end
      end
    end
  end

  // predictor: consensus of one accepted column and the results it releases
  task automatic merge_column(input logic [7:0] b1, input logic [7:0] b2,
                              input logic last);
    logic [7:0] cons;
    logic       lead;
    logic       emits;
    logic       holding;
    int         n;
    n = 0;
    if (b1 == b2 || b2 == GAP_BYTE) cons = b1;
    else if (b1 == GAP_BYTE)       cons = b2;
    else if (winner_sel == WIN_FIRST)  cons = b1;
    else if (winner_sel == WIN_SECOND) cons = b2;
    else                               cons = N_BYTE;

    // leading run follows the first read alone, whatever the setting
    lead    = leading && (b1 == GAP_BYTE);
    leading = lead;
    emits   = (cons != GAP_BYTE) && !(trim_on && lead);
    holding = trim_on && (b2 == GAP_BYTE);

    // any column that is not held flushes the hold store first
    if (!holding) begin
      foreach (held_q[i]) begin
        due_results.push_back({held_q[i], 1'b1, 1'b0, 1'b0});
        n++;
      end
      held_q.delete();
    end

    if (emits) begin
      if (holding) begin
        if (held_q.size() < HOLD_DEPTH) held_q.push_back(cons);
        else overflowed = 1'b1;
      end else begin
        due_results.push_back({cons, 1'b1, 1'b0, 1'b0});
        n++;
      end
    end

    // end of pair: mark the last word, or a bare marker if none came out
    if (last) begin
      if (n == 0) due_results.push_back({8'h00, 1'b0, 1'b0, 1'b0});
      due_results[due_results.size() - 1].eop = 1'b1;
      due_results[due_results.size() - 1].ovf = overflowed;
      leading    = 1'b1;
      overflowed = 1'b0;
      held_q.delete();
    end
  endtask

  // one column word; valid stays up into the next word unless a gap is drawn
  task automatic send_column(input logic [7:0] b1, input logic [7:0] b2,
                             input logic last);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      col_ch.valid <= 1'b0;
      @(posedge clk);
    end
    col_ch.valid       <= 1'b1;
    col_ch.base_one    <= b1;
    col_ch.base_two    <= b2;
    col_ch.last_column <= last;
    do @(posedge clk); while (!col_ch.ready);
    merge_column(b1, b2, last);
  endtask

  // sender holds off until every predicted word has arrived
  task automatic wait_for_results();
    col_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // quiet block: nothing due and the command queue run dry
  task automatic settle_block();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINNER) winner_sel = data;
    else trim_on = data[0];
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(7, 0))
      0, 1:    return GAP_BYTE;
      2:       return 8'($urandom_range(255, 0));
      3:       return N_BYTE;
      default: return NUCLEOTIDES[8 * $urandom_range(3, 0) +: 8];
    endcase
  endfunction

  function automatic logic [7:0] pick_base();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0)); while (b == GAP_BYTE);
    return b;
  endfunction

  // reset values: 'N' on mismatch, no trimming
  task automatic test_reset_values();
    send_column(8'h41, 8'h41, 1'b0);
    send_column(8'h00, 8'hFF, 1'b0);
    send_column(8'hFF, 8'hFF, 1'b0);
    send_column(GAP_BYTE, 8'h00, 1'b0);
    send_column(8'hFF, GAP_BYTE, 1'b0);
    // both gapped on the last column: bare end marker
    send_column(GAP_BYTE, GAP_BYTE, 1'b1);
    send_column(N_BYTE, 8'h43, 1'b1);
  endtask

  // every mismatch rule, both extremes among them
  task automatic test_winner_rules();
    logic [1:0] rules [4];
    rules = '{WIN_FIRST, WIN_SECOND, WIN_N_THREE, WIN_N_ZERO};
    foreach (rules[i]) begin
      settle_block();
      write_reg(CFG_WINNER, rules[i]);
      send_column(8'h47, 8'h54, 1'b0);
      send_column(8'h00, 8'hFF, 1'b1);
    end
  endtask

  // leading overhang dropped, trailing gap run held then released or lost
  task automatic test_overhang_trim();
    settle_block();
    write_reg(CFG_TRIM, CFG_DATA_W'(1));
    write_reg(CFG_WINNER, WIN_FIRST);
    send_column(GAP_BYTE, 8'h41, 1'b0);
    send_column(GAP_BYTE, GAP_BYTE, 1'b0);
    send_column(8'h43, 8'h43, 1'b0);
    // gap in the first read past the leading run is not an overhang
    send_column(GAP_BYTE, 8'h47, 1'b0);
    send_column(8'h54, GAP_BYTE, 1'b0);
    send_column(8'h41, GAP_BYTE, 1'b0);
    send_column(8'h43, 8'h47, 1'b0);
    send_column(8'h47, GAP_BYTE, 1'b0);
    // run reaches the end: held bases discarded
    send_column(8'h54, GAP_BYTE, 1'b1);
    // a pair that is nothing but leading overhang
    send_column(GAP_BYTE, 8'h41, 1'b1);
  endtask

  // trimming switched while a pair is open, with bases held
  task automatic test_setting_change();
    settle_block();
    write_reg(CFG_TRIM, CFG_DATA_W'(0));
    send_column(GAP_BYTE, 8'h41, 1'b0);
    settle_block();
    write_reg(CFG_TRIM, CFG_DATA_W'(1));
    // leading run still open, now dropped
    send_column(GAP_BYTE, 8'h43, 1'b0);
    send_column(8'h47, GAP_BYTE, 1'b0);
    settle_block();
    write_reg(CFG_TRIM, CFG_DATA_W'(0));
    // no longer held: flushes the held base first
    send_column(8'h54, GAP_BYTE, 1'b1);
  endtask

  // hold store filled past its depth, released, overflow flagged at the end
  task automatic test_hold_overflow();
    settle_block();
    write_reg(CFG_TRIM, CFG_DATA_W'(1));
    for (int i = 0; i < HOLD_DEPTH + 3; i++) send_column(pick_base(), GAP_BYTE, 1'b0);
    // longest burst: the full store and the releasing base
    send_column(pick_base(), pick_base(), 1'b0);
    send_column(pick_base(), GAP_BYTE, 1'b1);
  endtask

  // random pairs: mostly overhang-shaped with random content, some noise
  task automatic test_random_pairs(input int columns);
    int         sent;
    int         len;
    int         lead_len;
    int         tail_len;
    logic       noisy;
    logic [7:0] b1;
    logic [7:0] b2;
    sent = 0;
    while (sent < columns) begin
      if ($urandom_range(3, 0) == 0) begin
        settle_block();
        write_reg(CFG_WINNER, CFG_DATA_W'($urandom_range(3, 0)));
        write_reg(CFG_TRIM, CFG_DATA_W'($urandom_range(1, 0)));
      end
      if (sent == 0 || $urandom_range(7, 0) == 0) wait_for_results();
      len      = $urandom_range(12, 1);
      noisy    = ($urandom_range(5, 0) == 0);
      lead_len = $urandom_range(1, 0) ? $urandom_range(3, 1) : 0;
      tail_len = $urandom_range(1, 0) ? $urandom_range(5, 1) : 0;
      for (int col = 0; col < len; col++) begin
        if (noisy) begin
          b1 = 8'($urandom_range(255, 0));
          b2 = 8'($urandom_range(255, 0));
        end else if (col < lead_len) begin
          b1 = GAP_BYTE;
          b2 = pick_symbol();
        end else if (col >= len - tail_len) begin
          b1 = pick_symbol();
          b2 = GAP_BYTE;
        end else begin
          b1 = pick_symbol();
          b2 = $urandom_range(1, 0) ? b1 : pick_symbol();
        end
        send_column(b1, b2, col == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    // predictor starts from the reset state
    winner_sel   = WIN_N_ZERO;
    trim_on      = 1'b0;
    leading      = 1'b1;
    overflowed   = 1'b0;
    fail_count   = 0;
    cycles       = 0;
    src_idle_pct = 9;
    snk_idle_pct = 67;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_WINNER;
    cfg_data           <= '0;
    col_ch.valid       <= 1'b0;
    col_ch.base_one    <= '0;
    col_ch.base_two    <= '0;
    col_ch.last_column <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalling
    test_reset_values();
    test_winner_rules();
    test_overhang_trim();
    test_setting_change();
    test_hold_overflow();
    test_random_pairs(RANDOM_COLS);

    // sender mostly idle, receiver mostly ready
    settle_block();
    src_idle_pct = 67;
    snk_idle_pct = 9;
    test_random_pairs(RANDOM_COLS);

    // full rate both ways
    settle_block();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_pairs(RANDOM_COLS);

    // drain, then leave room for any stray word
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/prc_pkg.sv
rtl/core/prc_in_if.sv
rtl/core/prc_out_if.sv
rtl/core/prc_ram.sv
rtl/core/prc_front.sv
rtl/core/prc_queue.sv
rtl/core/prc_back.sv
rtl/core/paired_read_consensus_top.sv
dv/paired_read_consensus_top_tb.sv
